// ===== rtl/cwlm_pkg.sv =====
// Shared types, symbol codes and character classes for the column wildcard line matcher.
package cwlm_pkg;

	// Position arithmetic: the column register and the line byte count both fit in nine bits.
	localparam int unsigned POS_W = 9;

	localparam logic [7:0] SYM_STAR      = 8'h2A; // '*'
	localparam logic [7:0] SYM_ALNUM     = 8'h3F; // '?'
	localparam logic [7:0] SYM_LETTER    = 8'h40; // '@'
	localparam logic [7:0] SYM_DIGIT     = 8'h24; // '$'
	localparam logic [7:0] SYM_NONDIGIT  = 8'h23; // '#'
	localparam logic [7:0] SYM_NONLETTER = 8'h21; // '!'

	typedef enum logic [2:0] {
		REG_MATCH_COLUMN   = 3'd0,
		REG_PATTERN_LENGTH = 3'd1,
		REG_PATTERN_0      = 3'd2,
		REG_PATTERN_1      = 3'd3,
		REG_PATTERN_2      = 3'd4,
		REG_PATTERN_3      = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic matched;
		logic all_ok;
		logic star;
	} eval_t;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	// Outcome of one non-star symbol against one byte.
	function automatic logic symbol_ok(input logic [7:0] s, input logic [7:0] b);
		logic ok;
		case (s)
			SYM_ALNUM:     ok = is_letter(b) || is_digit(b);
			SYM_LETTER:    ok = is_letter(b);
			SYM_DIGIT:     ok = is_digit(b);
			SYM_NONDIGIT:  ok = !is_digit(b);
			SYM_NONLETTER: ok = !is_letter(b);
			default:       ok = (s == b);
		endcase
		return ok;
	endfunction

endpackage

// ===== rtl/cwlm_line_eval.sv =====
// Per-byte symbol check and end-of-line tail check against the zero padding.
module cwlm_line_eval #(
	parameter int unsigned MAX_PATTERN = 32
) (
	input  logic [cwlm_pkg::POS_W-1:0]  col,
	input  logic                        line_end,
	input  logic                        all_in,
	input  logic                        star_in,
	input  logic [7:0]                  char_byte,
	input  logic [7:0]                  match_column,
	input  logic [5:0]                  pattern_length,
	input  logic [MAX_PATTERN-1:0][7:0] syms,
	output cwlm_pkg::eval_t             res
);
	import cwlm_pkg::*;

	localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [POS_W-1:0]       start;
	logic [POS_W-1:0]       plen;
	logic [POS_W-1:0]       rel;
	logic [POS_W-1:0]       len;
	logic [POS_W-1:0]       k;
	logic                   in_rng;
	logic                   hit;
	logic [7:0]             sym;
	logic                   star1;
	logic                   all1;
	logic [MAX_PATTERN-1:0] rng;
	logic [MAX_PATTERN-1:0] st;
	logic [MAX_PATTERN-1:0] z;
	logic [MAX_PATTERN-1:0] sm;
	logic [MAX_PATTERN-1:0] first;
	logic [MAX_PATTERN-1:0] below;
	logic                   fail;

	always_comb begin
		start = (match_column == 8'd0) ? '0 : POS_W'(match_column) - POS_W'(1);
		plen  = (pattern_length > 6'(MAX_PATTERN)) ? POS_W'(MAX_PATTERN)
		                                           : POS_W'(pattern_length);
		rel    = col - start;
		in_rng = (col >= start) && (rel < plen);
		sym    = syms[rel[IW-1:0]];
		hit    = in_rng && !star_in;
		star1  = star_in || (hit && sym == SYM_STAR);
		all1   = all_in && !(hit && sym != SYM_STAR && !symbol_ok(sym, char_byte));

		// Tail: symbols past the line end see the byte zero, up to the first star.
		len = col + POS_W'(1);
		k   = (len > start) ? len - start : '0;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			rng[j] = (POS_W'(j) >= k) && (POS_W'(j) < plen);
			st[j]  = (syms[j] == SYM_STAR);
			z[j]   = symbol_ok(syms[j], 8'h00);
		end
		sm    = rng & st;
		first = sm & (~sm + MAX_PATTERN'(1));
		below = (sm == '0) ? '1 : first - MAX_PATTERN'(1);
		fail  = |(rng & ~z & ~st & below);

		res.star    = star1;
		res.all_ok  = all1;
		res.matched = line_end && (plen != '0) && (len >= plen) && all1 && (star1 || !fail);
	end

endmodule

// ===== rtl/column_wildcard_line_matcher.sv =====
// Top level of the column wildcard line matcher: registers, handshakes and counters.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tdata = char_byte, tlast = end_of_line
//  m_axis   | out | m_axis_tvalid/tready    | tdata = line_number, match_total; tuser = line_matched
//  cfg      | in  | cfg_we                  | cfg_index, cfg_data
//
// One byte per cycle unless a line result is stalled: a byte is registered, checked against
// its pattern symbol and folded into the line state in the next cycle; a line result is
// registered in the result register once the last byte of its line leaves the byte stage.
// Reset clears the line state, the line and match counters and sets the configuration to its
// defaults (column 1, empty pattern). A stalled result register holds the byte stage only when
// that byte ends a line; bytes inside a line keep flowing.
module column_wildcard_line_matcher #(
	parameter int unsigned MAX_LINE_BYTES = 79,
	parameter int unsigned MAX_PATTERN    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] line_number, [31:16] match_total
	output logic [0:0]  m_axis_tuser,   // [0] line_matched
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import cwlm_pkg::*;

	localparam int unsigned CW = $clog2(MAX_LINE_BYTES + 1);

	logic [7:0]                  match_column_q;
	logic [5:0]                  pattern_length_q;
	logic [MAX_PATTERN-1:0][7:0] syms_q;

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        eol_s1;

	logic [CW-1:0]               col_q;
	logic                        all_q;
	logic                        star_q;
	logic [15:0]                 lines_q;
	logic [15:0]                 matches_q;

	logic                        out_valid_q;
	logic                        matched_q;
	logic [15:0]                 line_num_q;
	logic [15:0]                 total_q;

	logic                        line_end;
	logic                        out_free;
	logic                        adv;
	logic [15:0]                 matches_next;
	eval_t                       res;

	assign line_end = eol_s1 || (col_q >= CW'(MAX_LINE_BYTES - 1));
	assign out_free = !out_valid_q || m_axis_tready;
	assign adv      = valid_s1 && (!line_end || out_free);
	assign s_axis_tready = !valid_s1 || adv;
	assign matches_next  = (res.matched && matches_q != 16'hFFFF) ? matches_q + 16'd1 : matches_q;

	cwlm_line_eval #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_eval (
		.col           (POS_W'(col_q)),
		.line_end      (line_end),
		.all_in        (all_q),
		.star_in       (star_q),
		.char_byte     (byte_s1),
		.match_column  (match_column_q),
		.pattern_length(pattern_length_q),
		.syms          (syms_q),
		.res           (res)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_column_q   <= 8'd1;
			pattern_length_q <= '0;
			syms_q           <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_MATCH_COLUMN) begin
				match_column_q <= cfg_data[7:0];
			end
			if (cfg_index == REG_PATTERN_LENGTH) begin
				pattern_length_q <= cfg_data[5:0];
			end
			for (int i = 0; i < MAX_PATTERN; i++) begin
				if (cfg_index == 3'(REG_PATTERN_0 + (i / 8))) begin
					syms_q[i] <= cfg_data[(i % 8) * 8 +: 8];
				end
			end
		end
	end

	// Byte stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eol_s1  <= s_axis_tlast;
		end
	end

	// Line state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			all_q     <= 1'b1;
			star_q    <= 1'b0;
			lines_q   <= '0;
			matches_q <= '0;
		end else if (adv) begin
			if (line_end) begin
				col_q     <= '0;
				all_q     <= 1'b1;
				star_q    <= 1'b0;
				lines_q   <= lines_q + 16'd1;
				matches_q <= matches_next;
			end else begin
				col_q  <= col_q + CW'(1);
				all_q  <= res.all_ok;
				star_q <= res.star;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && line_end;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && line_end) begin
			matched_q  <= res.matched;
			line_num_q <= lines_q + 16'd1;
			total_q    <= matches_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {total_q, line_num_q};
	assign m_axis_tuser  = matched_q;

`ifndef NO_ASSERTIONS
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < CW'(MAX_LINE_BYTES))
		else $error("column count ran past the line limit");

	a_star_mid_line: assert property (@(posedge clk) disable iff (!arst_n)
		star_q |-> (col_q != '0))
		else $error("star flag set at the start of a line");

	a_fail_mid_line: assert property (@(posedge clk) disable iff (!arst_n)
		!all_q |-> (col_q != '0))
		else $error("mismatch flag not cleared at line end");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && eol_s1 || m_axis_tvalid
			&& !m_axis_tready && col_q == CW'(MAX_LINE_BYTES - 1)))
		else $error("input held without a stalled line result");
`endif

endmodule
